// ===== rtl/core/lcdnw_pkg.sv =====
// Shared types, codes and microcode for the character LCD nibble writer.
// No dependencies; used by lcdnw_useq and char_lcd_nibble_writer.
package lcdnw_pkg;

	localparam int PC_W = 5;

	localparam logic [15:0] LEAD_US      = 16'd40000;
	localparam logic [12:0] FULL_GAP_US  = 13'd5000;
	localparam logic [12:0] CLEAR_GAP_US = 13'd1500;
	localparam logic [7:0]  HOME_ADDR    = 8'h80;

	typedef enum logic [2:0] {
		KIND_FULL  = 3'd0,
		KIND_SHORT = 3'd1,
		KIND_CMD   = 3'd2,
		KIND_DATA  = 3'd3,
		KIND_POS   = 3'd4,
		KIND_CLEAR = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		SRC_CONST,
		SRC_VALUE,
		SRC_ADDR
	} src_t;

	typedef enum logic [1:0] {
		GAP_NONE,
		GAP_CLEAR,
		GAP_FULL
	} gap_t;

	typedef struct packed {
		src_t       src;
		logic [7:0] cbyte;
		logic       rs;
		logic       lead;
		gap_t       gap;
		logic       done;
	} uword_t;

	typedef struct packed {
		logic   active;
		logic   low_half;
		uword_t uw;
	} step_t;

	localparam logic [PC_W-1:0] PC_FULL  = 5'd0;
	localparam logic [PC_W-1:0] PC_SHORT = 5'd12;
	localparam logic [PC_W-1:0] PC_CMD   = 5'd15;
	localparam logic [PC_W-1:0] PC_DATA  = 5'd16;
	localparam logic [PC_W-1:0] PC_POS   = 5'd17;
	localparam logic [PC_W-1:0] PC_CLEAR = 5'd18;

	function automatic logic [PC_W-1:0] entry_pc(input logic [2:0] kind);
		logic [PC_W-1:0] pc;
		case (kind)
			KIND_FULL:  pc = PC_FULL;
			KIND_SHORT: pc = PC_SHORT;
			KIND_CMD:   pc = PC_CMD;
			KIND_DATA:  pc = PC_DATA;
			KIND_POS:   pc = PC_POS;
			KIND_CLEAR: pc = PC_CLEAR;
			default:    pc = PC_FULL;
		endcase
		return pc;
	endfunction

	function automatic logic kind_ok(input logic [2:0] kind);
		return kind <= KIND_CLEAR;
	endfunction

	// One control word per byte: source, constant, RS, lead pause, gap, end of program.
	function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
		uword_t w;
		case (pc)
			5'd0:    w = '{SRC_CONST, 8'h03, 1'b0, 1'b1, GAP_FULL,  1'b0};
			5'd1:    w = '{SRC_CONST, 8'h03, 1'b0, 1'b0, GAP_FULL,  1'b0};
			5'd2:    w = '{SRC_CONST, 8'h03, 1'b0, 1'b0, GAP_FULL,  1'b0};
			5'd3:    w = '{SRC_CONST, 8'h28, 1'b0, 1'b0, GAP_FULL,  1'b0};
			5'd4:    w = '{SRC_CONST, 8'h28, 1'b0, 1'b0, GAP_FULL,  1'b0};
			5'd5:    w = '{SRC_CONST, 8'h08, 1'b0, 1'b0, GAP_FULL,  1'b0};
			5'd6:    w = '{SRC_CONST, 8'h01, 1'b0, 1'b0, GAP_FULL,  1'b0};
			5'd7:    w = '{SRC_CONST, 8'h10, 1'b0, 1'b0, GAP_FULL,  1'b0};
			5'd8:    w = '{SRC_CONST, 8'h06, 1'b0, 1'b0, GAP_FULL,  1'b0};
			5'd9:    w = '{SRC_CONST, 8'h02, 1'b0, 1'b0, GAP_FULL,  1'b0};
			5'd10:   w = '{SRC_CONST, 8'h28, 1'b0, 1'b0, GAP_FULL,  1'b0};
			5'd11:   w = '{SRC_CONST, 8'h0C, 1'b0, 1'b0, GAP_FULL,  1'b1};
			5'd12:   w = '{SRC_CONST, 8'h02, 1'b0, 1'b0, GAP_NONE,  1'b0};
			5'd13:   w = '{SRC_CONST, 8'h28, 1'b0, 1'b0, GAP_NONE,  1'b0};
			5'd14:   w = '{SRC_CONST, 8'h0C, 1'b0, 1'b0, GAP_NONE,  1'b1};
			5'd15:   w = '{SRC_VALUE, 8'h00, 1'b0, 1'b0, GAP_NONE,  1'b1};
			5'd16:   w = '{SRC_VALUE, 8'h00, 1'b1, 1'b0, GAP_NONE,  1'b1};
			5'd17:   w = '{SRC_ADDR,  8'h00, 1'b0, 1'b0, GAP_NONE,  1'b1};
			5'd18:   w = '{SRC_CONST, 8'h01, 1'b0, 1'b0, GAP_CLEAR, 1'b1};
			default: w = '{SRC_CONST, 8'h00, 1'b0, 1'b0, GAP_NONE,  1'b1};
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/core/lcdnw_useq.sv =====
// Microcode sequencer: step counter, nibble half bit and busy flag.
// Depends on lcdnw_pkg for the control word, entry points and ROM.
module lcdnw_useq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [2:0]         kind,
	output logic               busy,
	output lcdnw_pkg::step_t   step
);
	import lcdnw_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic            half_q;
	logic            busy_q;
	logic            take;
	uword_t          uw;

	assign take = start && !busy_q && kind_ok(kind);
	assign uw   = ucode_rom(pc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= '0;
			half_q <= 1'b0;
			busy_q <= 1'b0;
		end else if (take) begin
			pc_q   <= entry_pc(kind);
			half_q <= 1'b0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			half_q <= !half_q;
			if (half_q) begin
				if (uw.done) begin
					busy_q <= 1'b0;
				end else begin
					pc_q <= pc_q + PC_W'(1);
				end
			end
		end
	end

	assign busy          = busy_q;
	assign step.active   = busy_q;
	assign step.low_half = half_q;
	assign step.uw       = uw;

endmodule

// ===== rtl/core/char_lcd_nibble_writer.sv =====
// Character LCD nibble writer, top level: operand latch, byte select and output register.
// Start sets the sequencer busy flag, then the output register strobes the first nibble;
// the microcode step counter issues one nibble per cycle after that. Each item sends two
// nibbles per byte (12 for full init, 3 for short, 1 otherwise); a start is taken when idle.
// The receiver cannot stall; results are never held. Reset clears sequencer and strobe.
// Depends on lcdnw_pkg and lcdnw_useq.
module char_lcd_nibble_writer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  kind,
	input  logic [7:0]  value,
	input  logic [1:0]  row,
	input  logic [5:0]  column,
	output logic        strobe,
	output logic        reg_select,
	output logic [3:0]  nibble,
	output logic [15:0] pause_before_us,
	output logic [12:0] pause_after_us,
	output logic        last
);
	import lcdnw_pkg::*;

	step_t       step;
	logic [7:0]  value_q;
	logic [1:0]  row_q;
	logic [5:0]  column_q;
	logic [7:0]  addr;
	logic [7:0]  sel_byte;
	logic        strobe_q;
	logic        rs_q;
	logic [3:0]  nib_q;
	logic [15:0] before_q;
	logic [12:0] after_q;
	logic        last_q;

	lcdnw_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.busy   (busy),
		.step   (step)
	);

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			value_q  <= value;
			row_q    <= row;
			column_q <= column;
		end
	end

	always_comb begin
		case (row_q)
			2'd1:    addr = {2'b10, column_q};
			2'd2:    addr = {2'b11, column_q};
			default: addr = HOME_ADDR;
		endcase
		case (step.uw.src)
			SRC_VALUE: sel_byte = value_q;
			SRC_ADDR:  sel_byte = addr;
			default:   sel_byte = step.uw.cbyte;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= step.active;
		end
	end

	always_ff @(posedge clk) begin
		rs_q     <= step.uw.rs;
		nib_q    <= step.low_half ? sel_byte[3:0] : sel_byte[7:4];
		before_q <= (step.uw.lead && !step.low_half) ? LEAD_US : '0;
		last_q   <= step.low_half && step.uw.done;
		if (!step.low_half) begin
			after_q <= '0;
		end else begin
			case (step.uw.gap)
				GAP_FULL:  after_q <= FULL_GAP_US;
				GAP_CLEAR: after_q <= CLEAR_GAP_US;
				default:   after_q <= '0;
			endcase
		end
	end

	assign strobe          = strobe_q;
	assign reg_select      = rs_q;
	assign nibble          = nib_q;
	assign pause_before_us = before_q;
	assign pause_after_us  = after_q;
	assign last            = last_q;

`ifndef ASSERT_OFF
	a_strobe_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("strobe without active sequence");

	a_take_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind <= KIND_CLEAR) |=> busy)
		else $error("valid item not taken");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |=> !strobe)
		else $error("transfer after last nibble");

	a_lead_high_half: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && pause_before_us != 16'd0) |-> (!last && pause_after_us == 13'd0))
		else $error("lead pause on low nibble");
`endif

endmodule
